// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the deframer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dsfr_pkg.sv
// ---------------------------------------------------------------------------
// dsfr_pkg
// types and constants of the dle stuffed frame receiver
// ---------------------------------------------------------------------------
package dsfr_pkg;

  localparam int MAX_FRAME = 512;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int CMP_W     = ((CNT_W > 9) ? CNT_W : 9) + 1;

  localparam logic [7:0] BYTE_DLE = 8'h10;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam int         HDR_LEN  = 6;
  localparam int         FTR_LEN  = 6;
  localparam int         FTR_KEEP = 3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_IDLE_DLE  = 2'd1,
    ST_FRAME     = 2'd2,
    ST_FRAME_DLE = 2'd3
  } dfr_state_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] source_id;
    logic [7:0] payload_length;
    logic       header_ok;
    logic       footer_present;
    logic [7:0] power_pct;
    logic [7:0] rssi_pct;
    logic [7:0] bit_errors;
    logic       overflow;
  } res_t;

endpackage

// File: rtl/dsfr_deframer.sv
// ---------------------------------------------------------------------------
// dsfr_deframer
// framing state machine, unstuffing and frame registers, one byte per step
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dsfr_deframer import dsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  dfr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sender_r, sender_nxt;
  logic [7:0]       length_r, length_nxt;
  logic [7:0]       footer_r [FTR_KEEP];
  logic [7:0]       footer_nxt [FTR_KEEP];
  logic             ovf_r, ovf_nxt;

  logic             take;
  logic             full;
  logic [7:0]       len_eff;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] pay_end;
  logic [CMP_W-1:0] ftr_end;
  logic [CMP_W-1:0] diff;
  logic             is_pay;
  logic             is_ftr;
  logic             hdr;
  logic             ftr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      sender_r <= '0;
      length_r <= '0;
      ovf_r    <= 1'b0;
      for (int i = 0; i < FTR_KEEP; i++) begin
        footer_r[i] <= '0;
      end
    end else if (step) begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sender_r <= sender_nxt;
      length_r <= length_nxt;
      ovf_r    <= ovf_nxt;
      for (int i = 0; i < FTR_KEEP; i++) begin
        footer_r[i] <= footer_nxt[i];
      end
    end
  end

  assign full    = (count_r >= CNT_W'(MAX_FRAME));
  assign len_eff = (count_r == CNT_W'(5)) ? rx_byte : length_r;
  assign pos     = CMP_W'(count_r);
  assign pay_end = CMP_W'(HDR_LEN) + CMP_W'(len_eff);
  assign ftr_end = CMP_W'(HDR_LEN + FTR_LEN) + CMP_W'(length_r);
  assign diff    = pos - pay_end;
  assign is_pay  = (pos >= CMP_W'(HDR_LEN)) && (pos < pay_end);
  assign is_ftr  = (pos >= pay_end) && (diff < CMP_W'(FTR_KEEP));
  assign hdr     = (pos >= CMP_W'(HDR_LEN));
  assign ftr     = hdr && (pos >= ftr_end);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    sender_nxt = sender_r;
    length_nxt = length_r;
    ovf_nxt    = ovf_r;
    for (int i = 0; i < FTR_KEEP; i++) begin
      footer_nxt[i] = footer_r[i];
    end
    take = 1'b0;
    res  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (rx_byte == BYTE_DLE) begin
          state_nxt = ST_IDLE_DLE;
        end
      end
      ST_IDLE_DLE: begin
        if (rx_byte == BYTE_STX) begin
          state_nxt  = ST_FRAME;
          count_nxt  = '0;
          sender_nxt = '0;
          length_nxt = '0;
          ovf_nxt    = 1'b0;
          for (int i = 0; i < FTR_KEEP; i++) begin
            footer_nxt[i] = '0;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRAME: begin
        if (rx_byte == BYTE_DLE) begin
          state_nxt = ST_FRAME_DLE;
        end else begin
          take = 1'b1;
        end
      end
      ST_FRAME_DLE: begin
        if (rx_byte == BYTE_ETX) begin
          state_nxt          = ST_IDLE;
          res.valid          = 1'b1;
          res.kind           = KIND_SUMMARY;
          res.header_ok      = hdr;
          res.footer_present = ftr;
          res.overflow       = ovf_r;
          if (hdr) begin
            res.source_id      = sender_r;
            res.payload_length = length_r;
          end
          if (ftr) begin
            res.power_pct  = footer_r[0];
            res.rssi_pct   = footer_r[1];
            res.bit_errors = footer_r[2];
          end
        end else begin
          state_nxt = ST_FRAME;
          take      = (rx_byte == BYTE_DLE);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (take) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == '0) begin
          sender_nxt = rx_byte;
        end
        if (count_r == CNT_W'(5)) begin
          length_nxt = rx_byte;
        end
        if (is_pay) begin
          res.valid     = 1'b1;
          res.kind      = KIND_PAYLOAD;
          res.data_byte = rx_byte;
        end else if (is_ftr) begin
          unique case (diff[1:0])
            2'd0:    footer_nxt[0] = rx_byte;
            2'd1:    footer_nxt[1] = rx_byte;
            2'd2:    footer_nxt[2] = rx_byte;
            default: footer_nxt[0] = footer_r[0];
          endcase
        end
      end
    end
  end

  `ASSERT_RST(a_count_bound, (count_r <= CNT_W'(MAX_FRAME)), "frame count above maximum")
  `ASSERT_RST(a_ovf_full, (ovf_r |-> full), "overflow flag set below maximum count")
  `ASSERT_RST(a_summary_src, ((res.valid && res.kind == KIND_SUMMARY) |-> (state_r == ST_FRAME_DLE)), "summary outside escape state")
  `ASSERT_RST(a_payload_pos, ((res.valid && res.kind == KIND_PAYLOAD) |-> (hdr && !full)), "payload byte outside payload window")

endmodule

// File: rtl/dsfr_result_reg.sv
// ---------------------------------------------------------------------------
// dsfr_result_reg
// result register of the output channel
// ---------------------------------------------------------------------------
module dsfr_result_reg import dsfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  input  logic out_stall,
  output logic free,
  output logic out_valid,
  output res_t out_res
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  assign free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (free) begin
      out_valid_nxt = load && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/dle_stuffed_frame_receiver_unit.sv
// a transferred byte is held in the input register, and any result of it in the result register
// throughput: one byte per cycle while out_stall is low, one deframer state update per byte
// bytes that cause no result still take one pass through the input register
// reset: synchronous active-low rst_n, state idle, frame count and frame registers cleared
// ---------------------------------------------------------------------------
// dle_stuffed_frame_receiver_unit
// dle stx/etx deframer with byte unstuffing, payload and summary results
// ---------------------------------------------------------------------------
module dle_stuffed_frame_receiver_unit import dsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_source_id,
  output logic [7:0] out_payload_length,
  output logic       out_header_ok,
  output logic       out_footer_present,
  output logic [7:0] out_power_pct,
  output logic [7:0] out_rssi_pct,
  output logic [7:0] out_bit_errors,
  output logic       out_overflow
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] byte_r;
  logic       free;
  logic       step;
  res_t       res;
  res_t       out_res;

  assign step     = in_valid_r && free;
  assign in_stall = in_valid_r && !free;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // input transfer register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  dsfr_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .res     (res)
  );

  dsfr_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .out_stall (out_stall),
    .free      (free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_source_id      = out_res.source_id;
  assign out_payload_length = out_res.payload_length;
  assign out_header_ok      = out_res.header_ok;
  assign out_footer_present = out_res.footer_present;
  assign out_power_pct      = out_res.power_pct;
  assign out_rssi_pct       = out_res.rssi_pct;
  assign out_bit_errors     = out_res.bit_errors;
  assign out_overflow       = out_res.overflow;

endmodule
